// ===== design/dtf_pkg.sv =====
// Shared constants and a helper function for the decimal text to fixed point unit.
package dtf_pkg;

  // ASCII codes the parser reacts to.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Width of the result and of its saturated magnitude.
  localparam int OUT_W = 48;
  localparam int MAG_SAT_W = OUT_W - 1;

  // Width of the widest power of ten the divider uses (10^9 < 2^30).
  localparam int POW10_W = 30;

  // Number of parsed strings the queue between front and back can hold.
  localparam int QUEUE_DEPTH = 2;

  // Power of ten for a fraction digit count.
  function automatic logic [POW10_W-1:0] pow10(input logic [3:0] k);
    logic [POW10_W-1:0] p;
    case (k)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== design/dtf_front.sv =====
// Character parser: sign, integer and fraction accumulation, one character per cycle while the queue is not full.
module dtf_front #(
  parameter int INT_BITS        = 31,
  parameter int MAX_FRAC_DIGITS = 9,
  parameter int FRAC_ACC_W      = 30,
  parameter int NDIG_W          = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_char_code,
  input  logic                  in_end_of_string,
  // Parsed string toward the queue.
  output logic                  push,
  input  logic                  full,
  output logic                  job_neg,
  output logic [INT_BITS-1:0]   job_int,
  output logic [FRAC_ACC_W-1:0] job_frac,
  output logic [NDIG_W-1:0]     job_ndig
);

  localparam logic [INT_BITS+3:0] INT_MAX_EXT = {4'd0, {INT_BITS{1'b1}}};
  localparam logic [NDIG_W-1:0]   NDIG_MAX    = NDIG_W'(MAX_FRAC_DIGITS);

  logic                  neg_r, neg_nxt;
  logic [INT_BITS-1:0]   int_r, int_nxt;
  logic [FRAC_ACC_W-1:0] frac_r, frac_nxt;
  logic [NDIG_W-1:0]     ndig_r, ndig_nxt;
  logic                  in_frac_r, in_frac_nxt;
  logic                  stop_r, stop_nxt;
  logic                  start_r, start_nxt;

  logic                  accept;
  logic                  is_nul;
  logic                  ending;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [INT_BITS+3:0]   int_t;
  logic [FRAC_ACC_W+3:0] frac_t;

  // A request is taken whenever the queue has room for a finished string.
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;
  assign is_nul   = (in_char_code == dtf_pkg::CH_NUL);
  assign ending   = is_nul || in_end_of_string;
  assign is_digit = (in_char_code >= dtf_pkg::CH_ZERO) && (in_char_code <= dtf_pkg::CH_NINE);
  assign digit    = 4'(in_char_code - dtf_pkg::CH_ZERO);

  // Times ten plus digit as two shifted adds.
  assign int_t  = {1'b0, int_r, 3'b000} + {3'b000, int_r, 1'b0} + (INT_BITS+4)'(digit);
  assign frac_t = {1'b0, frac_r, 3'b000} + {3'b000, frac_r, 1'b0} + (FRAC_ACC_W+4)'(digit);

  // Parse one character into the next accumulator values.
  always_comb begin
    neg_nxt     = neg_r;
    int_nxt     = int_r;
    frac_nxt    = frac_r;
    ndig_nxt    = ndig_r;
    in_frac_nxt = in_frac_r;
    stop_nxt    = stop_r;
    start_nxt   = 1'b0;
    if (!is_nul && !stop_r) begin
      if (start_r && in_char_code == dtf_pkg::CH_MINUS) begin
        neg_nxt = 1'b1;
      end else if (start_r && in_char_code == dtf_pkg::CH_PLUS) begin
        neg_nxt = neg_r;
      end else if (is_digit) begin
        if (in_frac_r) begin
          if (ndig_r < NDIG_MAX) begin
            frac_nxt = frac_t[FRAC_ACC_W-1:0];
            ndig_nxt = ndig_r + NDIG_W'(1);
          end
        end else begin
          int_nxt = (int_t > INT_MAX_EXT) ? {INT_BITS{1'b1}} : int_t[INT_BITS-1:0];
        end
      end else if (in_char_code == dtf_pkg::CH_DOT) begin
        if (in_frac_r) begin
          stop_nxt = 1'b1;
        end else begin
          in_frac_nxt = 1'b1;
        end
      end else begin
        stop_nxt = 1'b1;
      end
    end
  end

  // A string that ends hands its parsed state to the queue.
  assign push     = accept && ending;
  assign job_neg  = neg_nxt;
  assign job_int  = int_nxt;
  assign job_frac = frac_nxt;
  assign job_ndig = ndig_nxt;

  // Accumulator state; cleared at reset and after each string.
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      neg_r     <= 1'b0;
      int_r     <= '0;
      frac_r    <= '0;
      ndig_r    <= '0;
      in_frac_r <= 1'b0;
      stop_r    <= 1'b0;
      start_r   <= 1'b1;
    end else if (accept) begin
      neg_r     <= neg_nxt;
      int_r     <= int_nxt;
      frac_r    <= frac_nxt;
      ndig_r    <= ndig_nxt;
      in_frac_r <= in_frac_nxt;
      stop_r    <= stop_nxt;
      start_r   <= start_nxt;
    end
  end

endmodule

// ===== design/dtf_queue.sv =====
// Short first-in first-out queue of parsed strings between parser and converter.
module dtf_queue #(
  parameter int W = 66
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rd_data
);

  localparam int PTR_W = $clog2(dtf_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(dtf_pkg::QUEUE_DEPTH + 1);

  logic [W-1:0]     mem_r [dtf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full    = (cnt_r == CNT_W'(dtf_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(dtf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(dtf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/dtf_back.sv =====
// Converter: divides the fraction by a power of ten bit by bit and forms the result.
module dtf_back #(
  parameter int INT_BITS   = 31,
  parameter int FRAC_BITS  = 16,
  parameter int FRAC_ACC_W = 30,
  parameter int NDIG_W     = 4,
  parameter int DIV_W      = 30
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Parsed string from the queue.
  input  logic                  empty,
  output logic                  pop,
  input  logic                  job_neg,
  input  logic [INT_BITS-1:0]   job_int,
  input  logic [FRAC_ACC_W-1:0] job_frac,
  input  logic [NDIG_W-1:0]     job_ndig,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [47:0]           out_value
);

  localparam int MAG_W = INT_BITS + FRAC_BITS;
  localparam int EXT_W = (MAG_W > dtf_pkg::OUT_W) ? MAG_W : dtf_pkg::OUT_W;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  state_t              state_r;
  logic                neg_r;
  logic [INT_BITS-1:0] int_r;
  logic [DIV_W-1:0]    rem_r;
  logic [DIV_W-1:0]    div_r;
  logic [FRAC_BITS-1:0] quo_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r;
  logic [47:0]         out_value_r;

  logic [DIV_W:0]              rem2;
  logic                        ge;
  logic [DIV_W-1:0]            rem_nxt;
  logic [dtf_pkg::POW10_W-1:0] pow_sel;
  logic [MAG_W-1:0]            mag;
  logic [EXT_W-1:0]            mag_ext;
  logic [dtf_pkg::MAG_SAT_W-1:0] mag_sat;
  logic [47:0]                 pos;
  logic [47:0]                 res_nxt;
  logic                        out_free;

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = (state_r == S_IDLE) && !empty;

  // Divisor for the number of fraction digits of the string at the queue head.
  assign pow_sel = dtf_pkg::pow10(4'(job_ndig));

  // One restoring division step: shift the remainder and try the divisor.
  assign rem2    = {rem_r, 1'b0};
  assign ge      = (rem2 >= {1'b0, div_r});
  assign rem_nxt = ge ? DIV_W'(rem2 - {1'b0, div_r}) : rem2[DIV_W-1:0];

  // Integer and fraction bits side by side, saturated, then signed.
  assign mag     = {int_r, quo_r};
  assign mag_ext = EXT_W'(mag);
  assign mag_sat = (|mag_ext[EXT_W-1:dtf_pkg::MAG_SAT_W]) ? {dtf_pkg::MAG_SAT_W{1'b1}}
                                                         : mag_ext[dtf_pkg::MAG_SAT_W-1:0];
  assign pos     = {1'b0, mag_sat};
  assign res_nxt = neg_r ? (~pos + 48'd1) : pos;

  // Sequencer, divider registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            neg_r   <= job_neg;
            int_r   <= job_int;
            rem_r   <= DIV_W'(job_frac);
            div_r   <= pow_sel[DIV_W-1:0];
            quo_r   <= '0;
            cnt_r   <= CNT_W'(FRAC_BITS);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[FRAC_BITS-2:0], ge};
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_value_r <= res_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The partial remainder always stays below the divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < div_r))
    else $error("division remainder not below divisor");

  // The divider runs exactly FRAC_BITS steps before the result stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV) && (cnt_r == CNT_W'(1))) |=> (state_r == S_FIN))
    else $error("divider step count off");

  // A finished conversion leaves a valid result behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && out_free) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("finished conversion did not produce a result");

endmodule

// ===== design/decimal_text_to_fixed_point_unit.sv =====
// Top level of the decimal text to fixed point unit: parser, queue and converter.
//
// Usage: one ASCII character per input request on in_char_code, with
// in_end_of_string marking the last character (a NUL character also ends the
// string and is not parsed). Each string gives one out_value request: a signed
// number with FRAC_BITS fraction bits, truncated toward zero, the magnitude
// saturating at 2^47-1 and the integer part at 2^INT_BITS-1.
// Throughput: the parser takes one character every cycle while the queue is not
// full. The converter divides the fraction by 10^k one quotient bit per cycle
// and takes the next string only after registering the current result; a
// two-entry queue lets the parser run ahead by up to two finished strings, and
// in_stall rises only while the queue is full.
// After the ending character is accepted, its string enters the queue, is popped
// by an idle converter, divided in S_DIV and registered in S_FIN with out_valid.
// Reset (rst_n low, synchronous) empties the queue and the output register and
// puts the parser at the start of a string. A stall on out_stall holds the
// result steady; the converter then waits with its next result, and the parser
// keeps taking characters until the queue fills.
module decimal_text_to_fixed_point_unit #(
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 9,
  parameter int INT_BITS        = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_value
);

  localparam int FRAC_ACC_W = $clog2(10 ** MAX_FRAC_DIGITS);
  localparam int DIV_W      = $clog2(10 ** MAX_FRAC_DIGITS + 1);
  localparam int NDIG_W     = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int JOB_W      = 1 + INT_BITS + FRAC_ACC_W + NDIG_W;

  logic                  push, full, pop, empty;
  logic                  f_neg, b_neg;
  logic [INT_BITS-1:0]   f_int, b_int;
  logic [FRAC_ACC_W-1:0] f_frac, b_frac;
  logic [NDIG_W-1:0]     f_ndig, b_ndig;
  logic [JOB_W-1:0]      q_wr, q_rd;

  // Parser.
  dtf_front #(
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
    .FRAC_ACC_W      (FRAC_ACC_W),
    .NDIG_W          (NDIG_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_string (in_end_of_string),
    .push             (push),
    .full             (full),
    .job_neg          (f_neg),
    .job_int          (f_int),
    .job_frac         (f_frac),
    .job_ndig         (f_ndig)
  );

  // Queue of parsed strings.
  assign q_wr = {f_neg, f_int, f_frac, f_ndig};
  assign {b_neg, b_int, b_frac, b_ndig} = q_rd;

  dtf_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (q_wr),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .rd_data (q_rd)
  );

  // Converter.
  dtf_back #(
    .INT_BITS   (INT_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .FRAC_ACC_W (FRAC_ACC_W),
    .NDIG_W     (NDIG_W),
    .DIV_W      (DIV_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .job_neg   (b_neg),
    .job_int   (b_int),
    .job_frac  (b_frac),
    .job_ndig  (b_ndig),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value)
  );

endmodule
